FILE: rtl/atavg_pkg.sv
// Shared types and constants for the temperature averaging block.
// Holds the fixed-point sample type, the divide-by-nine offset table and the
// ASCII codes used by the readout. No dependencies.
`default_nettype none

package atavg_pkg;

	// Running average and temperature, in 1/256 of a hundredth of a degree.
	typedef logic signed [25:0] avg_t;

	localparam int ADC_W = 12;
	localparam int CAL_W = 12;
	localparam int CHAR_W = 6;

	localparam logic signed [CAL_W-1:0] CALIB_RESET = -12'sd400;

	// code / 9 by reciprocal: floor(code * 3641 / 2^15) is exact for 12-bit codes
	localparam logic [11:0] DIV9_RECIP = 12'd3641;
	localparam int DIV9_SHIFT = 15;

	// 200 * 256 * 9 / 9: weight of one step of code/9
	localparam logic [25:0] STEP_WEIGHT = 26'd51200;

	// Readout reciprocals, exact for values up to 9999
	localparam logic [12:0] RECIP_10 = 13'd6554;   // >> 16
	localparam logic [12:0] RECIP_100 = 13'd5243;  // >> 19
	localparam logic [13:0] RECIP_1000 = 14'd8389; // >> 23

	localparam logic [13:0] H_MAX = 14'd9999;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_POINT = 6'd46;
	localparam logic [2:0] LAST_CHAR_IDX = 3'd4;

	// floor((51200*r - 70016000) / 9) for the remainder r of code / 9
	function automatic avg_t div9_rem_term(input logic [3:0] r);
		avg_t t;
		case (r)
			4'd0: t = -26'sd7779556;
			4'd1: t = -26'sd7773867;
			4'd2: t = -26'sd7768178;
			4'd3: t = -26'sd7762489;
			4'd4: t = -26'sd7756800;
			4'd5: t = -26'sd7751112;
			4'd6: t = -26'sd7745423;
			4'd7: t = -26'sd7739734;
			4'd8: t = -26'sd7734045;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/adc_temperature_average_ascii_top.sv
// Temperature sensor averaging with ASCII decimal readout, top level.
// Depends on atavg_pkg and atavg_readout.
//
// Usage:
//   Input channel (in_valid/in_ready, adc_sample): one 12-bit sensor code per
//   transaction. Each code becomes a temperature in hundredths of a degree
//   plus the calibration offset, and is folded into a running average
//   (add, then halve) that restarts every WINDOW samples.
//   Config channel (cfg_valid/cfg_ready, calib_offset_hundredths): always
//   ready; write only while the block is idle. Reset value is -4.00 degrees.
//   Output channel (out_valid/out_ready, ascii_char, last_char): after each
//   completed window, five characters "TU.th", last_char set on the fifth.
// Timing:
//   One sample per cycle. The first character is valid once the readout has
//   clamped and split the window's average, then one character per cycle
//   while out_ready is high. The readout holds one window; samples keep
//   flowing while it drains, and in_ready drops only if the next window
//   completes before the previous five characters have all been taken.
// Reset: arst_n clears the average, the window count, the pipeline and the
//   readout, and restores the calibration offset.
`default_nettype none

module adc_temperature_average_ascii_top import atavg_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [ADC_W-1:0]         adc_sample,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [CHAR_W-1:0]             ascii_char,
	output logic                          last_char,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic signed [CAL_W-1:0]  calib_offset_hundredths
);

	localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

	logic signed [CAL_W-1:0] calib_q;
	logic                    v_s1;
	logic [8:0]              quot_s1;
	logic [3:0]              rem_s1;
	avg_t                    avg_q;
	logic [CNT_W-1:0]        count_q;

	logic [23:0]  div_prod;
	logic [8:0]   quot;
	logic [11:0]  rem_full;
	logic         window_end;
	logic         advance;
	logic         rd_ready;
	logic [25:0]  step_part;
	avg_t         temp;
	avg_t         prev;
	logic [26:0]  sum;
	avg_t         avg_next;

	// code = 9*quot + rem
	assign div_prod = 24'(adc_sample) * 24'(DIV9_RECIP);
	assign quot = div_prod[23:DIV9_SHIFT];
	assign rem_full = adc_sample - 12'(quot) * 12'd9;

	assign window_end = (count_q == CNT_LAST);
	assign advance = v_s1 && (!window_end || rd_ready);
	assign in_ready = !v_s1 || advance;
	assign cfg_ready = 1'b1;

	assign step_part = 26'(quot_s1) * STEP_WEIGHT;
	assign temp = avg_t'(step_part) + div9_rem_term(rem_s1)
		+ avg_t'({{(26 - CAL_W - 8){calib_q[CAL_W-1]}}, calib_q, 8'b0});
	assign prev = (count_q == '0) ? '0 : avg_q;
	assign sum = {prev[25], prev} + {temp[25], temp};
	assign avg_next = sum[26:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= CALIB_RESET;
			v_s1 <= 1'b0;
			avg_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_valid) begin
				calib_q <= calib_offset_hundredths;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (advance) begin
				avg_q <= avg_next;
				count_q <= window_end ? '0 : count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			quot_s1 <= quot;
			rem_s1 <= rem_full[3:0];
		end
	end

	atavg_readout u_readout (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_valid   (advance && window_end),
		.ld_ready   (rd_ready),
		.ld_avg     (avg_next),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && window_end && !rd_ready))
		else $error("input stalled without a busy readout");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && window_end) |=> (!rd_ready && count_q == '0))
		else $error("window completion not handed to readout");

endmodule

`default_nettype wire

FILE: rtl/atavg_readout.sv
// Decimal readout: clamps a window average to 00.00..99.99, splits it into
// four digits and sends five ASCII characters on a valid/ready channel.
// Depends on atavg_pkg.
`default_nettype none

module atavg_readout import atavg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ld_valid,
	output logic                   ld_ready,
	input  wire avg_t              ld_avg,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CHAR_W-1:0]      ascii_char,
	output logic                   last_char
);

	localparam logic [2:0] RD_IDLE  = 3'd0;
	localparam logic [2:0] RD_CLAMP = 3'd1;
	localparam logic [2:0] RD_QUOT  = 3'd2;
	localparam logic [2:0] RD_DIGIT = 3'd3;
	localparam logic [2:0] RD_SEND  = 3'd4;

	logic [2:0]       state_q;
	avg_t             avg_q;
	logic [13:0]      h_q;
	logic [9:0]       q10_q;
	logic [6:0]       q100_q;
	logic [3:0]       q1000_q;
	logic [3:0][3:0]  dig_q;   // [3] tens of degrees .. [0] hundredths
	logic [2:0]       idx_q;
	logic [CHAR_W-1:0] char_q;

	logic signed [17:0] h_full;
	logic [13:0]        h_clamp;
	logic [26:0]        p10;
	logic [26:0]        p100;
	logic [27:0]        p1000;
	logic [13:0]        rem0;
	logic [9:0]         rem1;
	logic [6:0]         rem2;
	logic [2:0]         idx_next;

	function automatic logic [CHAR_W-1:0] char_code(input logic [2:0] idx,
			input logic [3:0][3:0] dig);
		logic [CHAR_W-1:0] c;
		case (idx)
			3'd0: c = ASCII_ZERO + {2'b00, dig[3]};
			3'd1: c = ASCII_ZERO + {2'b00, dig[2]};
			3'd2: c = ASCII_POINT;
			3'd3: c = ASCII_ZERO + {2'b00, dig[1]};
			default: c = ASCII_ZERO + {2'b00, dig[0]};
		endcase
		return c;
	endfunction

	assign h_full = avg_q[25:8];

	always_comb begin
		if (h_full[17]) begin
			h_clamp = '0;
		end else if (h_full > 18'sd9999) begin
			h_clamp = H_MAX;
		end else begin
			h_clamp = h_full[13:0];
		end
	end

	assign p10 = 27'(h_q) * 27'(RECIP_10);
	assign p100 = 27'(h_q) * 27'(RECIP_100);
	assign p1000 = 28'(h_q) * 28'(RECIP_1000);

	assign rem0 = h_q - 14'(q10_q) * 14'd10;
	assign rem1 = q10_q - 10'(q100_q) * 10'd10;
	assign rem2 = q100_q - 7'(q1000_q) * 7'd10;

	assign idx_next = idx_q + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
		end else begin
			case (state_q)
				RD_IDLE:  if (ld_valid) state_q <= RD_CLAMP;
				RD_CLAMP: state_q <= RD_QUOT;
				RD_QUOT:  state_q <= RD_DIGIT;
				RD_DIGIT: state_q <= RD_SEND;
				RD_SEND:  if (out_ready && idx_q == LAST_CHAR_IDX) state_q <= RD_IDLE;
				default:  state_q <= RD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == RD_IDLE && ld_valid) begin
			avg_q <= ld_avg;
		end
		if (state_q == RD_CLAMP) begin
			h_q <= h_clamp;
		end
		if (state_q == RD_QUOT) begin
			q10_q <= p10[25:16];
			q100_q <= p100[25:19];
			q1000_q <= p1000[26:23];
		end
		if (state_q == RD_DIGIT) begin
			dig_q <= {q1000_q, rem2[3:0], rem1[3:0], rem0[3:0]};
			char_q <= ASCII_ZERO + {2'b00, q1000_q};
			idx_q <= '0;
		end else if (state_q == RD_SEND && out_ready) begin
			idx_q <= idx_next;
			char_q <= char_code(idx_next, dig_q);
		end
	end

	assign ld_ready = (state_q == RD_IDLE);
	assign out_valid = (state_q == RD_SEND);
	assign ascii_char = char_q;
	assign last_char = (idx_q == LAST_CHAR_IDX);

	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RD_CLAMP) |-> $past(ld_valid && ld_ready))
		else $error("readout left idle without a load");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dig_q[0] <= 4'd9 && dig_q[1] <= 4'd9 && dig_q[2] <= 4'd9
			&& dig_q[3] <= 4'd9))
		else $error("digit out of decimal range");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((ascii_char >= ASCII_ZERO && ascii_char <= 6'd57)
			|| (ascii_char == ASCII_POINT && idx_q == 3'd2)))
		else $error("bad readout character");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_char) |=> ld_ready)
		else $error("readout did not return to idle after last character");

endmodule

`default_nettype wire
